// ===== rtl/core/pbcq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package pbcq_pkg;

   localparam int ENTRY_W = 18;

   localparam logic [2:0] OP_SET   = 3'd0;
   localparam logic [2:0] OP_CLR   = 3'd1;
   localparam logic [2:0] OP_READ  = 3'd2;
   localparam logic [2:0] OP_FLUSH = 3'd3;
   localparam logic [2:0] OP_WIPE  = 3'd4;

   localparam logic [1:0] KIND_ACK   = 2'd0;
   localparam logic [1:0] KIND_READ  = 2'd1;
   localparam logic [1:0] KIND_FLUSH = 2'd2;
   localparam logic [1:0] KIND_DONE  = 2'd3;

   localparam logic REG_ROW_BYTES = 1'b0;
   localparam logic REG_ROWS      = 1'b1;

   typedef enum logic [4:0] {
      S_WIPE  = 5'b00001,
      S_IDLE  = 5'b00010,
      S_MOD   = 5'b00100,
      S_FLUSH = 5'b01000,
      S_DONE  = 5'b10000
   } state_type;

   typedef struct packed {
      logic clear;
      logic push;
      logic fetch;
      logic pop;
   } qctl_type;

   typedef struct packed {
      logic empty;
      logic full;
      logic one_left;
   } qstat_type;

endpackage

`default_nettype wire

// ===== rtl/core/packed_bitmap_with_change_queue_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// One-bit-per-pixel frame buffer, eight pixels to a byte, with a FIFO of
// pixel changes. Set, clear and read each read the pixel-memory byte into
// a register, then, once the result side is free, check it, write it back
// and load the result. A flush fetches the queue head, then delivers one
// queued change per cycle while the result side does not stall; a flush of
// an empty queue returns nothing. Clear-all sweeps the pixel memory one
// byte per cycle, all MAX_ROW_BYTES*MAX_ROWS bytes (16384 by default), then
// returns its done item. After reset the same sweep runs with req_stall
// high and no result; configuration writes are taken throughout.
module packed_bitmap_with_change_queue_unit #(
   parameter int MAX_ROW_BYTES = 64,
   parameter int MAX_ROWS      = 256,
   parameter int QUEUE_DEPTH   = 32
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [2:0] req_operation,
   input  wire logic [8:0] req_x,
   input  wire logic [7:0] req_y,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic      [1:0] rsp_kind,
   output logic      [8:0] rsp_px,
   output logic      [7:0] rsp_py,
   output logic            rsp_pixel_value,
   output logic            rsp_in_range,
   output logic            rsp_changed,
   output logic            rsp_dropped,
   output logic            rsp_last,
   input  wire logic       csr_we,
   input  wire logic       csr_index,
   input  wire logic [8:0] csr_wdata
);

   localparam int STORE_BYTES = MAX_ROW_BYTES * MAX_ROWS;
   localparam int AW = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
   localparam int LW = (AW > 16) ? AW : 16;

   pbcq_pkg::state_type state_ff, state_in;

   logic [6:0]    row_bytes_ff;
   logic [8:0]    rows_ff;
   logic [2:0]    op_ff;
   logic [8:0]    x_ff;
   logic [7:0]    y_ff;
   logic          inr_ff;
   logic [AW-1:0] addr_ff;
   logic [AW-1:0] wipe_cnt_ff, wipe_cnt_in;
   logic          report_ff, report_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [1:0]    rsp_kind_ff, rsp_kind_in;
   logic [8:0]    rsp_px_ff, rsp_px_in;
   logic [7:0]    rsp_py_ff, rsp_py_in;
   logic          rsp_pv_ff, rsp_pv_in;
   logic          rsp_inr_ff, rsp_inr_in;
   logic          rsp_chg_ff, rsp_chg_in;
   logic          rsp_drp_ff, rsp_drp_in;
   logic          rsp_last_ff, rsp_last_in;

   logic          accept, out_free, load_out, capture;
   logic [6:0]    eff_rb;
   logic [8:0]    eff_rows;
   logic [14:0]   prod;
   logic [LW-1:0] sum_w;
   logic [AW-1:0] addr_c;
   logic          inr_c;

   logic          pix_we, pix_re;
   logic [AW-1:0] pix_waddr;
   logic [7:0]    pix_wdata, pix_rdata, mask, new_byte;
   logic          cur_bit, wval, is_write, flip;

   pbcq_pkg::qctl_type           qctl;
   pbcq_pkg::qstat_type          qstat;
   logic [pbcq_pkg::ENTRY_W-1:0] q_rdata;

   assign req_stall = (state_ff != pbcq_pkg::S_IDLE);
   assign accept    = req_valid & ~req_stall;
   assign out_free  = ~rsp_valid_ff | ~rsp_stall;

   // address of the requested byte, with oversized registers saturated
   assign eff_rb   = (32'(row_bytes_ff) > MAX_ROW_BYTES) ? 7'(MAX_ROW_BYTES) : row_bytes_ff;
   assign eff_rows = (32'(rows_ff) > MAX_ROWS) ? 9'(MAX_ROWS) : rows_ff;
   assign prod     = 15'(req_y) * 15'(eff_rb);
   assign sum_w    = LW'(prod) + LW'(req_x[8:3]);
   assign addr_c   = sum_w[AW-1:0];
   assign inr_c    = ({1'b0, req_x[8:3]} < eff_rb) && ({1'b0, req_y} < eff_rows);

   assign cur_bit  = pix_rdata[x_ff[2:0]];
   assign wval     = (op_ff == pbcq_pkg::OP_SET);
   assign is_write = (op_ff != pbcq_pkg::OP_READ);
   assign flip     = inr_ff & is_write & (cur_bit != wval);
   assign mask     = 8'(1) << x_ff[2:0];
   assign new_byte = wval ? (pix_rdata | mask) : (pix_rdata & ~mask);

   always_comb begin
      state_in     = state_ff;
      wipe_cnt_in  = wipe_cnt_ff;
      report_in    = report_ff;
      capture      = 1'b0;
      load_out     = 1'b0;
      pix_re       = 1'b0;
      pix_we       = 1'b0;
      pix_waddr    = addr_ff;
      pix_wdata    = new_byte;
      qctl         = '0;
      rsp_kind_in  = rsp_kind_ff;
      rsp_px_in    = rsp_px_ff;
      rsp_py_in    = rsp_py_ff;
      rsp_pv_in    = rsp_pv_ff;
      rsp_inr_in   = rsp_inr_ff;
      rsp_chg_in   = rsp_chg_ff;
      rsp_drp_in   = rsp_drp_ff;
      rsp_last_in  = rsp_last_ff;
      unique case (state_ff)
         pbcq_pkg::S_WIPE: begin
            pix_we    = 1'b1;
            pix_waddr = wipe_cnt_ff;
            pix_wdata = '0;
            if (wipe_cnt_ff == AW'(STORE_BYTES - 1)) begin
               state_in = report_ff ? pbcq_pkg::S_DONE : pbcq_pkg::S_IDLE;
            end else begin
               wipe_cnt_in = wipe_cnt_ff + AW'(1);
            end
         end
         pbcq_pkg::S_IDLE: begin
            if (accept) begin
               unique case (req_operation) inside
                  pbcq_pkg::OP_SET, pbcq_pkg::OP_CLR, pbcq_pkg::OP_READ: begin
                     capture  = 1'b1;
                     pix_re   = 1'b1;
                     state_in = pbcq_pkg::S_MOD;
                  end
                  pbcq_pkg::OP_FLUSH: begin
                     if (!qstat.empty) begin
                        qctl.fetch = 1'b1;
                        state_in   = pbcq_pkg::S_FLUSH;
                     end
                  end
                  pbcq_pkg::OP_WIPE: begin
                     qctl.clear  = 1'b1;
                     wipe_cnt_in = '0;
                     report_in   = 1'b1;
                     state_in    = pbcq_pkg::S_WIPE;
                  end
                  default: begin
                  end
               endcase
            end
         end
         pbcq_pkg::S_MOD: begin
            if (out_free) begin
               load_out    = 1'b1;
               pix_we      = flip;
               qctl.push   = flip & ~qstat.full;
               rsp_kind_in = is_write ? pbcq_pkg::KIND_ACK : pbcq_pkg::KIND_READ;
               rsp_px_in   = x_ff;
               rsp_py_in   = y_ff;
               rsp_pv_in   = is_write ? wval : (inr_ff & cur_bit);
               rsp_inr_in  = inr_ff;
               rsp_chg_in  = flip;
               rsp_drp_in  = flip & qstat.full;
               rsp_last_in = 1'b1;
               state_in    = pbcq_pkg::S_IDLE;
            end
         end
         pbcq_pkg::S_FLUSH: begin
            if (out_free) begin
               load_out    = 1'b1;
               qctl.pop    = 1'b1;
               rsp_kind_in = pbcq_pkg::KIND_FLUSH;
               rsp_px_in   = q_rdata[17:9];
               rsp_py_in   = q_rdata[8:1];
               rsp_pv_in   = q_rdata[0];
               rsp_inr_in  = 1'b1;
               rsp_chg_in  = 1'b1;
               rsp_drp_in  = 1'b0;
               rsp_last_in = qstat.one_left;
               if (qstat.one_left) begin
                  state_in = pbcq_pkg::S_IDLE;
               end
            end
         end
         pbcq_pkg::S_DONE: begin
            if (out_free) begin
               load_out    = 1'b1;
               rsp_kind_in = pbcq_pkg::KIND_DONE;
               rsp_px_in   = '0;
               rsp_py_in   = '0;
               rsp_pv_in   = 1'b0;
               rsp_inr_in  = 1'b1;
               rsp_chg_in  = 1'b0;
               rsp_drp_in  = 1'b0;
               rsp_last_in = 1'b1;
               report_in   = 1'b0;
               state_in    = pbcq_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = pbcq_pkg::S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pbcq_pkg::S_WIPE;
         wipe_cnt_ff  <= '0;
         report_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         row_bytes_ff <= '0;
         rows_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         wipe_cnt_ff  <= wipe_cnt_in;
         report_ff    <= report_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               pbcq_pkg::REG_ROW_BYTES: row_bytes_ff <= csr_wdata[6:0];
               pbcq_pkg::REG_ROWS:      rows_ff      <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (capture) begin
         op_ff   <= req_operation;
         x_ff    <= req_x;
         y_ff    <= req_y;
         inr_ff  <= inr_c;
         addr_ff <= addr_c;
      end
      rsp_kind_ff <= rsp_kind_in;
      rsp_px_ff   <= rsp_px_in;
      rsp_py_ff   <= rsp_py_in;
      rsp_pv_ff   <= rsp_pv_in;
      rsp_inr_ff  <= rsp_inr_in;
      rsp_chg_ff  <= rsp_chg_in;
      rsp_drp_ff  <= rsp_drp_in;
      rsp_last_ff <= rsp_last_in;
   end

   pbcq_ram #(
      .WIDTH (8),
      .DEPTH (STORE_BYTES)
   ) u_pixels (
      .clock (clock),
      .we    (pix_we),
      .waddr (pix_waddr),
      .wdata (pix_wdata),
      .re    (pix_re),
      .raddr (addr_c),
      .rdata (pix_rdata)
   );

   pbcq_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .ctl   (qctl),
      .wdata ({x_ff, y_ff, wval}),
      .rdata (q_rdata),
      .stat  (qstat)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kind        = rsp_kind_ff;
   assign rsp_px          = rsp_px_ff;
   assign rsp_py          = rsp_py_ff;
   assign rsp_pixel_value = rsp_pv_ff;
   assign rsp_in_range    = rsp_inr_ff;
   assign rsp_changed     = rsp_chg_ff;
   assign rsp_dropped     = rsp_drp_ff;
   assign rsp_last        = rsp_last_ff;

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      qctl.push |-> !qstat.full)
      else $error("change queue written while full");

   a_flush_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pbcq_pkg::S_FLUSH) |-> !qstat.empty)
      else $error("flush running on an empty queue");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      load_out |-> (!rsp_valid_ff || !rsp_stall))
      else $error("pending result overwritten");

   a_done_after_wipe: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pbcq_pkg::S_DONE) |-> report_ff)
      else $error("clear done without a clear request");

endmodule

`default_nettype wire

// ===== rtl/core/pbcq_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pbcq_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 16,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              we,
   input  wire logic [ADDR_W-1:0] waddr,
   input  wire logic [WIDTH-1:0]  wdata,
   input  wire logic              re,
   input  wire logic [ADDR_W-1:0] raddr,
   output logic      [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ===== rtl/core/pbcq_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pbcq_queue #(
   parameter int DEPTH = 32
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire pbcq_pkg::qctl_type          ctl,
   input  wire logic [pbcq_pkg::ENTRY_W-1:0] wdata,
   output logic      [pbcq_pkg::ENTRY_W-1:0] rdata,
   output pbcq_pkg::qstat_type              stat
);

   localparam int QW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [QW-1:0] head_ff, head_in, head_nx;
   logic [QW-1:0] tail_ff, tail_in, tail_nx;
   logic [CW-1:0] count_ff, count_in;
   logic          re;
   logic [QW-1:0] raddr;

   assign head_nx = (head_ff == QW'(DEPTH - 1)) ? '0 : head_ff + QW'(1);
   assign tail_nx = (tail_ff == QW'(DEPTH - 1)) ? '0 : tail_ff + QW'(1);

   assign stat.empty    = (count_ff == '0);
   assign stat.full     = (count_ff == CW'(DEPTH));
   assign stat.one_left = (count_ff == CW'(1));

   // a pop with more left fetches the next head at once
   assign raddr = ctl.pop ? head_nx : head_ff;
   assign re    = ctl.fetch | (ctl.pop & ~stat.one_left);

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (ctl.clear) begin
         head_in  = '0;
         tail_in  = '0;
         count_in = '0;
      end else begin
         if (ctl.push) begin
            tail_in = tail_nx;
         end
         if (ctl.pop) begin
            head_in = head_nx;
         end
         count_in = count_ff + CW'(ctl.push) - CW'(ctl.pop);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   pbcq_ram #(
      .WIDTH (pbcq_pkg::ENTRY_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (ctl.push),
      .waddr (tail_ff),
      .wdata (wdata),
      .re    (re),
      .raddr (raddr),
      .rdata (rdata)
   );

endmodule

`default_nettype wire

// ===== test/packed_bitmap_with_change_queue_unit_tb.sv =====
`timescale 1ns / 1ps

localparam int MAX_ROW_BYTES = 64;
localparam int MAX_ROWS      = 256;
localparam int QUEUE_DEPTH   = 32;
localparam int STORE_BYTES   = MAX_ROW_BYTES * MAX_ROWS;

typedef struct packed {
   logic [1:0] kind;
   logic [8:0] px;
   logic [7:0] py;
   logic       pixel_value;
   logic       in_range;
   logic       changed;
   logic       dropped;
   logic       last;
} pixel_result_type;

typedef struct packed {
   logic [8:0] x;
   logic [7:0] y;
   logic       value;
} pixel_change_type;

class pixel_scoreboard;
   logic [7:0]       pixel_bytes [STORE_BYTES];
   pixel_change_type changes [$];
   pixel_result_type expected [$];
   int unsigned      width_bytes;
   int unsigned      height_rows;
   int               errors;

   function new();
      foreach (pixel_bytes[i]) pixel_bytes[i] = 8'h00;
      width_bytes = 0;
      height_rows = 0;
      errors      = 0;
   endfunction

   function void write_reg(logic idx, logic [8:0] value);
      if (idx == pbcq_pkg::REG_ROW_BYTES) begin
         width_bytes = 32'(value[6:0]);
      end else begin
         height_rows = 32'(value);
      end
   endfunction

   function int unsigned eff_width();
      return (width_bytes > MAX_ROW_BYTES) ? MAX_ROW_BYTES : width_bytes;
   endfunction

   function int unsigned eff_height();
      return (height_rows > MAX_ROWS) ? MAX_ROWS : height_rows;
   endfunction

   function bit locate(logic [8:0] x, logic [7:0] y, output int unsigned addr);
      addr = 0;
      if (32'(x[8:3]) >= eff_width() || 32'(y) >= eff_height()) return 1'b0;
      addr = 32'(x[8:3]) + 32'(y) * eff_width();
      return 1'b1;
   endfunction

   function bit pixel_at(logic [8:0] x, logic [7:0] y);
      int unsigned a;
      if (!locate(x, y, a)) return 1'b0;
      return pixel_bytes[a][x[2:0]];
   endfunction

   function int pending();
      return expected.size();
   endfunction

   function void push_result(logic [1:0] kind, logic [8:0] px, logic [7:0] py,
                             logic v, logic inr, logic chg, logic drp, logic lst);
      expected.push_back({kind, px, py, v, inr, chg, drp, lst});
   endfunction

   // predicted effect of one accepted item
   function void note_request(logic [2:0] op, logic [8:0] x, logic [7:0] y);
      int unsigned      a;
      bit               inr;
      logic             v;
      logic             chg;
      logic             drp;
      pixel_change_type c;
      case (op) inside
         pbcq_pkg::OP_SET, pbcq_pkg::OP_CLR: begin
            v   = (op == pbcq_pkg::OP_SET);
            chg = 1'b0;
            drp = 1'b0;
            inr = locate(x, y, a);
            if (inr && pixel_bytes[a][x[2:0]] != v) begin
               chg = 1'b1;
               pixel_bytes[a][x[2:0]] = v;
               if (changes.size() < QUEUE_DEPTH) begin
                  changes.push_back({x, y, v});
               end else begin
                  drp = 1'b1;
               end
            end
            push_result(pbcq_pkg::KIND_ACK, x, y, v, inr, chg, drp, 1'b1);
         end
         pbcq_pkg::OP_READ: begin
            inr = locate(x, y, a);
            v   = inr ? pixel_bytes[a][x[2:0]] : 1'b0;
            push_result(pbcq_pkg::KIND_READ, x, y, v, inr, 1'b0, 1'b0, 1'b1);
         end
         pbcq_pkg::OP_FLUSH: begin
            while (changes.size() > 0) begin
               c = changes.pop_front();
               push_result(pbcq_pkg::KIND_FLUSH, c.x, c.y, c.value, 1'b1, 1'b1, 1'b0,
                           changes.size() == 0);
            end
         end
         pbcq_pkg::OP_WIPE: begin
            foreach (pixel_bytes[i]) pixel_bytes[i] = 8'h00;
            changes.delete();
            push_result(pbcq_pkg::KIND_DONE, '0, '0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1);
         end
         default: ;
      endcase
   endfunction

   task report(string what);
      $display("%0t mismatch: %s", $time, what);
      errors++;
   endtask

   task compare(string name, int got, int want);
      if (got != want) report($sformatf("%s got %0d want %0d", name, got, want));
   endtask

   task check_response(pixel_result_type got);
      pixel_result_type want;
      if (expected.size() == 0) begin
         report($sformatf("result with nothing pending: kind %0d px %0d py %0d",
                          got.kind, got.px, got.py));
      end else begin
         want = expected.pop_front();
         compare("kind", int'(got.kind), int'(want.kind));
         compare("px", int'(got.px), int'(want.px));
         compare("py", int'(got.py), int'(want.py));
         compare("pixel_value", int'(got.pixel_value), int'(want.pixel_value));
         compare("in_range", int'(got.in_range), int'(want.in_range));
         compare("changed", int'(got.changed), int'(want.changed));
         compare("dropped", int'(got.dropped), int'(want.dropped));
         compare("last", int'(got.last), int'(want.last));
      end
   endtask
endclass

module packed_bitmap_with_change_queue_unit_tb;

   localparam int WATCHDOG_LIMIT = 60000;
   localparam int LONG_HOLD      = 400;
   localparam int SETTLE_CYCLES  = 8;
   localparam int END_CYCLES     = 20;

   localparam logic [2:0] OP_UNUSED_LO  = 3'd5;
   localparam logic [2:0] OP_UNUSED_MID = 3'd6;
   localparam logic [2:0] OP_UNUSED_HI  = 3'd7;

   typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_mode_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [2:0] req_operation = pbcq_pkg::OP_READ;
   logic [8:0] req_x = '0;
   logic [7:0] req_y = '0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [1:0] rsp_kind;
   logic [8:0] rsp_px;
   logic [7:0] rsp_py;
   logic       rsp_pixel_value;
   logic       rsp_in_range;
   logic       rsp_changed;
   logic       rsp_dropped;
   logic       rsp_last;
   logic       csr_we = 1'b0;
   logic       csr_index = pbcq_pkg::REG_ROW_BYTES;
   logic [8:0] csr_wdata = '0;

   pixel_scoreboard sb = new();

   int             idle_cycles = 0;
   int             burst_left = 0;
   int             wipes_left = 4;
   bit             valid_up = 1'b0;
   bit             hold_request = 1'b0;
   int             hold_left = 0;
   int             mode_left = 0;
   stall_mode_type stall_mode = STALL_NONE;

   packed_bitmap_with_change_queue_unit uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_operation   (req_operation),
      .req_x           (req_x),
      .req_y           (req_y),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_kind        (rsp_kind),
      .rsp_px          (rsp_px),
      .rsp_py          (rsp_py),
      .rsp_pixel_value (rsp_pixel_value),
      .rsp_in_range    (rsp_in_range),
      .rsp_changed     (rsp_changed),
      .rsp_dropped     (rsp_dropped),
      .rsp_last        (rsp_last),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // result side stall pattern, with a long hold-off when one is requested
   always @(posedge clock) begin
      if (hold_request) begin
         hold_request = 1'b0;
         hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         if (mode_left == 0) begin
            stall_mode = stall_mode_type'($urandom_range(0, 3));
            mode_left = $urandom_range(10, 80);
         end
         mode_left--;
         case (stall_mode)
            STALL_NONE:  rsp_stall <= 1'b0;
            STALL_LIGHT: rsp_stall <= ($urandom_range(0, 4) == 0);
            STALL_HEAVY: rsp_stall <= ($urandom_range(0, 9) < 6);
            default:     rsp_stall <= ~rsp_stall;
         endcase
      end
   end

   always @(posedge clock) begin : monitor
      pixel_result_type seen;
      bit               took_req;
      bit               took_rsp;
      if (reset) begin
         idle_cycles = 0;
      end else begin
         took_req = req_valid && !req_stall;
         took_rsp = rsp_valid && !rsp_stall;
         if (took_rsp) begin
            seen = {rsp_kind, rsp_px, rsp_py, rsp_pixel_value, rsp_in_range,
                    rsp_changed, rsp_dropped, rsp_last};
            sb.check_response(seen);
         end
         if (took_req) sb.note_request(req_operation, req_x, req_y);
         if (took_req || took_rsp) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t watchdog: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("[packed_bitmap_with_change_queue_unit] ERROR");
            $finish;
         end
      end
   end

   // offer one item; valid stays up while a burst goes on
   task send_item(logic [2:0] op, logic [8:0] x, logic [7:0] y);
      req_valid     <= 1'b1;
      req_operation <= op;
      req_x         <= x;
      req_y         <= y;
      valid_up = 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         valid_up = 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 8);
      end else begin
         burst_left--;
      end
   endtask

   task wait_idle();
      if (valid_up) begin
         req_valid <= 1'b0;
         valid_up = 1'b0;
      end
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task set_config(logic [6:0] width, logic [8:0] height);
      csr_we    <= 1'b1;
      csr_index <= pbcq_pkg::REG_ROW_BYTES;
      csr_wdata <= {2'b00, width};
      @(posedge clock);
      sb.write_reg(pbcq_pkg::REG_ROW_BYTES, {2'b00, width});
      csr_index <= pbcq_pkg::REG_ROWS;
      csr_wdata <= height;
      @(posedge clock);
      sb.write_reg(pbcq_pkg::REG_ROWS, height);
      csr_we <= 1'b0;
   endtask

   task run_phase(int count, int flush_pct);
      int         done_items;
      int         r;
      logic [2:0] op;
      logic [8:0] x;
      logic [7:0] y;
      done_items = 0;
      while (done_items < count) begin
         r = $urandom_range(0, 99);
         if ($urandom_range(0, 99) < 85 && sb.eff_width() > 0 && sb.eff_height() > 0) begin
            x = 9'($urandom_range(0, 8 * sb.eff_width() - 1));
            y = 8'($urandom_range(0, sb.eff_height() - 1));
         end else begin
            x = 9'($urandom_range(0, 511));
            y = 8'($urandom_range(0, 255));
         end
         if (r < flush_pct) begin
            op = pbcq_pkg::OP_FLUSH;
         end else if (r < flush_pct + 2) begin
            op = 3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
         end else if (r < flush_pct + 4 && wipes_left > 0) begin
            op = pbcq_pkg::OP_WIPE;
            wipes_left--;
         end else if (r < flush_pct + 18) begin
            op = pbcq_pkg::OP_READ;
         end else if ($urandom_range(0, 9) < 7) begin
            // mostly flip the stored bit so the change queue fills
            op = sb.pixel_at(x, y) ? pbcq_pkg::OP_CLR : pbcq_pkg::OP_SET;
         end else begin
            op = $urandom_range(0, 1) ? pbcq_pkg::OP_SET : pbcq_pkg::OP_CLR;
         end
         send_item(op, x, y);
         if (op <= pbcq_pkg::OP_WIPE) done_items++;
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // registers still at reset: everything is outside
      send_item(pbcq_pkg::OP_SET, 9'd0, 8'd0);
      send_item(pbcq_pkg::OP_READ, 9'd511, 8'd255);
      wait_idle();

      set_config(7'd2, 9'd3);
      send_item(pbcq_pkg::OP_SET, 9'd0, 8'd0);
      send_item(pbcq_pkg::OP_SET, 9'd0, 8'd0);
      send_item(pbcq_pkg::OP_SET, 9'd15, 8'd2);
      send_item(pbcq_pkg::OP_READ, 9'd15, 8'd2);
      send_item(pbcq_pkg::OP_CLR, 9'd15, 8'd2);
      send_item(pbcq_pkg::OP_CLR, 9'd15, 8'd2);
      send_item(pbcq_pkg::OP_READ, 9'd16, 8'd0);
      send_item(pbcq_pkg::OP_READ, 9'd0, 8'd3);
      send_item(pbcq_pkg::OP_FLUSH, 9'd0, 8'd0);
      send_item(pbcq_pkg::OP_FLUSH, 9'd0, 8'd0);
      send_item(OP_UNUSED_LO, 9'd1, 8'd1);
      send_item(OP_UNUSED_MID, 9'd2, 8'd1);
      send_item(OP_UNUSED_HI, 9'd3, 8'd1);
      send_item(pbcq_pkg::OP_SET, 9'd7, 8'd1);
      send_item(pbcq_pkg::OP_WIPE, 9'd0, 8'd0);
      send_item(pbcq_pkg::OP_READ, 9'd7, 8'd1);
      send_item(pbcq_pkg::OP_FLUSH, 9'd0, 8'd0);
      wait_idle();

      // oversized registers saturate
      set_config(7'd127, 9'd511);
      send_item(pbcq_pkg::OP_SET, 9'd511, 8'd255);
      send_item(pbcq_pkg::OP_READ, 9'd511, 8'd255);
      send_item(pbcq_pkg::OP_SET, 9'd256, 8'd128);
      send_item(pbcq_pkg::OP_FLUSH, 9'd0, 8'd0);
      wait_idle();

      set_config(7'd2, 9'd4);
      run_phase(70, 3);
      wait_idle();

      set_config(7'd64, 9'd256);
      run_phase(20, 8);
      hold_request = 1'b1;
      run_phase(40, 8);
      wait_idle();

      set_config(7'd127, 9'd511);
      run_phase(50, 10);
      wait_idle();

      set_config(7'd1, 9'd1);
      run_phase(20, 5);
      wait_idle();
      run_phase(20, 5);
      wait_idle();

      set_config(7'd5, 9'd3);
      run_phase(50, 2);
      wait_idle();

      set_config(7'd0, 9'd256);
      run_phase(15, 5);
      wait_idle();

      set_config(7'd64, 9'd0);
      run_phase(15, 5);
      wait_idle();

      set_config(7'd3, 9'd200);
      run_phase(50, 6);
      wait_idle();

      repeat (END_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("[packed_bitmap_with_change_queue_unit] OK");
      end else begin
         $display("[packed_bitmap_with_change_queue_unit] ERROR");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/pbcq_pkg.sv
rtl/core/pbcq_ram.sv
rtl/core/pbcq_queue.sv
rtl/core/packed_bitmap_with_change_queue_unit.sv
test/packed_bitmap_with_change_queue_unit_tb.sv
